// ===== hw/rtl/ist_pkg.sv =====
// ist_pkg: opcodes, status codes, sequencer states and compare flags for the
// interval set tracker. Depends on nothing.
package ist_pkg;

  localparam logic [1:0] OP_ADD    = 2'd0;
  localparam logic [1:0] OP_REMOVE = 2'd1;
  localparam logic [1:0] OP_QUERY  = 2'd2;
  localparam logic [1:0] OP_NONE   = 2'd3;

  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_FULL  = 2'd1;
  localparam logic [1:0] STATUS_EMPTY = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_EVAL,
    S_SECOND,
    S_TAIL,
    S_COMMIT,
    S_REPORT
  } state_t;

  // entry start/end against the working span edges
  typedef struct packed {
    logic s_lt_l;
    logic s_eq_l;
    logic s_lt_r;
    logic s_eq_r;
    logic e_lt_l;
    logic e_eq_l;
    logic e_lt_r;
    logic e_eq_r;
  } cmp_flags_t;

endpackage

// ===== hw/rtl/interval_set_tracker.sv =====
// interval_set_tracker: top level, sequencer walking the interval table.
// Depends on ist_pkg, ist_cmp and ist_table.
//
// Keeps a sorted set of disjoint half-open intervals. Pulse start while busy
// is low to transfer an opcode and two edges; busy stays high until the
// one-cycle done strobe that carries covered, status and interval_count, which
// must be taken in that cycle. An operation walks every stored entry; an add
// that inserts before an entry or a remove that splits one also passes through
// S_SECOND to write the second entry, and an empty span or unused opcode goes
// straight to S_REPORT. The walk is paced by the single table read port:
// each entry is read, compared against the span and rewritten into the other
// table bank, which becomes live only if the result fits. No clearing pass
// after reset.
module interval_set_tracker #(
  parameter int MAX_INTERVALS = 16,
  parameter int COORD_BITS    = 31
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  input  logic [1:0]                           opcode,
  input  logic [COORD_BITS-1:0]                left_edge,
  input  logic [COORD_BITS-1:0]                right_edge,
  output logic                                 busy,
  output logic                                 done,
  output logic                                 covered,
  output logic [1:0]                           status,
  output logic [$clog2(MAX_INTERVALS+1)-1:0]   interval_count
);

  import ist_pkg::*;

  localparam int IDX_BITS  = $clog2(MAX_INTERVALS);
  localparam int ADDR_BITS = IDX_BITS + 1;
  localparam int CNT_BITS  = $clog2(MAX_INTERVALS + 1);
  localparam int WCNT_BITS = $clog2(MAX_INTERVALS + 2);
  localparam int DATA_BITS = 2 * COORD_BITS;

  state_t state, state_next;

  logic [1:0]            op;
  logic [COORD_BITS-1:0] cur_l, cur_r;
  logic [CNT_BITS-1:0]   idx, idx_inc;
  logic [CNT_BITS-1:0]   count;
  logic [WCNT_BITS-1:0]  wcnt;
  logic                  bank;
  logic                  placed;
  logic                  hit;
  logic [1:0]            stat;

  logic                  in_empty;
  logic                  last_entry;
  logic                  rd_en, wr_req, wr_en, need_second;
  logic [COORD_BITS-1:0] wr_start, wr_end;
  logic [COORD_BITS-1:0] rd_start, rd_end;
  logic [DATA_BITS-1:0]  rd_data;
  cmp_flags_t            flags;

  logic keep_add, after_add, keep_rem, left_rem, right_rem, span_cover, merge_l, merge_r;

  assign rd_start = rd_data[DATA_BITS-1:COORD_BITS];
  assign rd_end   = rd_data[COORD_BITS-1:0];

  ist_table #(
    .DATA_BITS (DATA_BITS),
    .ADDR_BITS (ADDR_BITS)
  ) u_table (
    .clk     (clk),
    .rd_en   (rd_en),
    .rd_addr ({bank, idx[IDX_BITS-1:0]}),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr ({~bank, wcnt[IDX_BITS-1:0]}),
    .wr_data ({wr_start, wr_end})
  );

  ist_cmp #(
    .COORD_BITS (COORD_BITS)
  ) u_cmp (
    .entry_start (rd_start),
    .entry_end   (rd_end),
    .span_left   (cur_l),
    .span_right  (cur_r),
    .flags       (flags)
  );

  assign in_empty   = !(left_edge < right_edge);
  assign idx_inc    = idx + CNT_BITS'(1);
  assign last_entry = (idx_inc == count);

  assign keep_add   = flags.e_lt_l;
  assign after_add  = !flags.s_lt_r && !flags.s_eq_r;
  assign keep_rem   = flags.e_lt_l || flags.e_eq_l || !flags.s_lt_r;
  assign left_rem   = flags.s_lt_l;
  assign right_rem  = !flags.e_lt_r && !flags.e_eq_r;
  assign span_cover = (flags.s_lt_l || flags.s_eq_l) && !flags.e_lt_r;
  assign merge_l    = flags.s_lt_l;
  assign merge_r    = !flags.e_lt_r && !flags.e_eq_r;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          if (opcode == OP_NONE || in_empty) begin
            state_next = S_REPORT;
          end else if (count == '0) begin
            state_next = S_TAIL;
          end else begin
            state_next = S_READ;
          end
        end
      end
      S_READ: state_next = S_EVAL;
      S_EVAL: begin
        if (need_second) begin
          state_next = S_SECOND;
        end else if (last_entry) begin
          state_next = S_TAIL;
        end else begin
          state_next = S_READ;
        end
      end
      S_SECOND: state_next = last_entry ? S_TAIL : S_READ;
      S_TAIL:   state_next = S_COMMIT;
      S_COMMIT: state_next = S_REPORT;
      S_REPORT: state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  // outputs and table writes
  always_comb begin
    rd_en       = 1'b0;
    wr_req      = 1'b0;
    wr_start    = cur_l;
    wr_end      = cur_r;
    need_second = 1'b0;
    unique case (state)
      S_READ: rd_en = 1'b1;
      S_EVAL: begin
        unique case (op)
          OP_ADD: begin
            if (keep_add) begin
              wr_req   = 1'b1;
              wr_start = rd_start;
              wr_end   = rd_end;
            end else if (after_add) begin
              wr_req = 1'b1;
              if (placed) begin
                wr_start = rd_start;
                wr_end   = rd_end;
              end else begin
                need_second = 1'b1;
              end
            end
          end
          OP_REMOVE: begin
            if (keep_rem) begin
              wr_req   = 1'b1;
              wr_start = rd_start;
              wr_end   = rd_end;
            end else if (left_rem) begin
              wr_req      = 1'b1;
              wr_start    = rd_start;
              wr_end      = cur_l;
              need_second = right_rem;
            end else if (right_rem) begin
              wr_req   = 1'b1;
              wr_start = cur_r;
              wr_end   = rd_end;
            end
          end
          default: ;
        endcase
      end
      S_SECOND: begin
        wr_req   = 1'b1;
        wr_start = (op == OP_ADD) ? rd_start : cur_r;
        wr_end   = rd_end;
      end
      S_TAIL: wr_req = (op == OP_ADD) && !placed;
      default: ;
    endcase
  end

  assign wr_en          = wr_req && (wcnt < WCNT_BITS'(MAX_INTERVALS));
  assign busy           = (state != S_IDLE);
  assign done           = (state == S_REPORT);
  assign covered        = hit;
  assign status         = stat;
  assign interval_count = count;

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      bank  <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_COMMIT && (op == OP_ADD || op == OP_REMOVE) &&
          wcnt <= WCNT_BITS'(MAX_INTERVALS)) begin
        bank  <= ~bank;
        count <= wcnt[CNT_BITS-1:0];
      end
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    if (state == S_IDLE && start) begin
      op     <= opcode;
      cur_l  <= left_edge;
      cur_r  <= right_edge;
      idx    <= '0;
      wcnt   <= '0;
      placed <= 1'b0;
      hit    <= 1'b0;
      stat   <= (opcode != OP_NONE && in_empty) ? STATUS_EMPTY : STATUS_OK;
    end else begin
      if (wr_req) begin
        wcnt <= wcnt + WCNT_BITS'(1);
      end
      if ((state == S_EVAL && !need_second) || state == S_SECOND) begin
        idx <= idx_inc;
      end
      if (state == S_EVAL) begin
        if (op == OP_ADD && !keep_add && !after_add) begin
          if (merge_l) begin
            cur_l <= rd_start;
          end
          if (merge_r) begin
            cur_r <= rd_end;
          end
        end
        if (op == OP_ADD && !keep_add && after_add) begin
          placed <= 1'b1;
        end
        if (op == OP_QUERY && span_cover) begin
          hit <= 1'b1;
        end
      end
      if (state == S_COMMIT && (op == OP_ADD || op == OP_REMOVE) &&
          wcnt > WCNT_BITS'(MAX_INTERVALS)) begin
        stat <= STATUS_FULL;
      end
    end
  end

`ifndef SYNTHESIS
  a_report_frees: assert property (@(posedge clk) disable iff (rst)
    done |=> !busy)
    else $error("block still busy after result");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("transfer accepted without going busy");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    done |-> (interval_count <= CNT_BITS'(MAX_INTERVALS)))
    else $error("interval count beyond capacity");

  a_full_keeps: assert property (@(posedge clk) disable iff (rst)
    (done && status == STATUS_FULL) |-> $stable(interval_count))
    else $error("refused operation changed the table");

  a_cover_ok: assert property (@(posedge clk) disable iff (rst)
    (done && status != STATUS_OK) |-> !covered)
    else $error("coverage reported on a refused or empty operation");
`endif

endmodule

// ===== hw/rtl/ist_cmp.sv =====
// ist_cmp: shared compare unit, one stored entry against the working span.
// Depends on ist_pkg for the flag struct.
module ist_cmp #(
  parameter int COORD_BITS = 31
) (
  input  logic [COORD_BITS-1:0] entry_start,
  input  logic [COORD_BITS-1:0] entry_end,
  input  logic [COORD_BITS-1:0] span_left,
  input  logic [COORD_BITS-1:0] span_right,
  output ist_pkg::cmp_flags_t   flags
);

  always_comb begin
    flags.s_lt_l = entry_start < span_left;
    flags.s_eq_l = entry_start == span_left;
    flags.s_lt_r = entry_start < span_right;
    flags.s_eq_r = entry_start == span_right;
    flags.e_lt_l = entry_end < span_left;
    flags.e_eq_l = entry_end == span_left;
    flags.e_lt_r = entry_end < span_right;
    flags.e_eq_r = entry_end == span_right;
  end

endmodule

// ===== hw/rtl/ist_table.sv =====
// ist_table: two-bank interval table, one write and one registered read port.
// Depends on nothing.
module ist_table #(
  parameter int DATA_BITS = 62,
  parameter int ADDR_BITS = 5
) (
  input  logic                 clk,
  input  logic                 rd_en,
  input  logic [ADDR_BITS-1:0] rd_addr,
  output logic [DATA_BITS-1:0] rd_data,
  input  logic                 wr_en,
  input  logic [ADDR_BITS-1:0] wr_addr,
  input  logic [DATA_BITS-1:0] wr_data
);

  logic [DATA_BITS-1:0] mem [2**ADDR_BITS];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
